### rtl/grid_ray_march_dda_macros.svh
// assertion macros for the grid ray march block
`ifndef GRID_RAY_MARCH_DDA_MACROS_SVH
`define GRID_RAY_MARCH_DDA_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define GRMD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define GRMD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/grmd_pkg.sv
// shared types and constants of the grid ray march block
package grmd_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int CELL_W      = 6;
    localparam int VALUE_W     = 8;
    localparam int POS_W       = 22;
    localparam int DIR_W       = 16;
    localparam int DIST_W      = 32;
    localparam int STEPS_W     = 14;
    localparam int ITERS       = 32;
    localparam int ITER_W      = 5;
    localparam int CMP_W       = 35;
    localparam int MUL_A_W     = FRAC_BITS + 1;
    localparam int MUL_P_W     = MUL_A_W + DIST_W;

    localparam logic [VALUE_W-1:0]   WALL_LEVEL  = 8'd48;
    localparam logic [STEPS_W-1:0]   STEPS_RESET = 14'd256;
    localparam logic [FRAC_BITS:0]   FRAC_ONE    = 17'h10000;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam logic [1:0] SIDE_XP = 2'd0;
    localparam logic [1:0] SIDE_XN = 2'd1;
    localparam logic [1:0] SIDE_YN = 2'd2;
    localparam logic [1:0] SIDE_YP = 2'd3;

    localparam logic REG_MAX_STEPS = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQRT,
        ST_DIV_X,
        ST_DIV_Y,
        ST_FS_X,
        ST_FS_Y,
        ST_STEP,
        ST_TEST,
        ST_OUT
    } state_t;

endpackage

### rtl/grmd_alu.sv
// shared compare-subtract unit and multiplier
module grmd_alu (
    input  logic [grmd_pkg::CMP_W-1:0]   cmp_a,
    input  logic [grmd_pkg::CMP_W-1:0]   cmp_b,
    output logic                         cmp_ge,
    output logic [grmd_pkg::CMP_W-1:0]   cmp_diff,
    input  logic [grmd_pkg::MUL_A_W-1:0] mul_a,
    input  logic [grmd_pkg::DIST_W-1:0]  mul_b,
    output logic [grmd_pkg::MUL_P_W-1:0] mul_p
);

    logic [grmd_pkg::CMP_W:0] sub;

    // borrow out of the wide subtract gives the compare
    assign sub      = {1'b0, cmp_a} - {1'b0, cmp_b};
    assign cmp_ge   = ~sub[grmd_pkg::CMP_W];
    assign cmp_diff = sub[grmd_pkg::CMP_W-1:0];
    assign mul_p    = grmd_pkg::MUL_P_W'(mul_a) * grmd_pkg::MUL_P_W'(mul_b);

endmodule

### rtl/grmd_map.sv
// map cell memory with clearing sweep after reset
module grmd_map #(
    parameter int ADDR_W = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [grmd_pkg::VALUE_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [grmd_pkg::VALUE_W-1:0] rd_data,
    output logic                         busy
);

    logic [grmd_pkg::VALUE_W-1:0] mem [2**ADDR_W];
    logic [ADDR_W:0]              clr_cnt_reg;
    logic [grmd_pkg::VALUE_W-1:0] rd_data_reg;

    assign busy    = ~clr_cnt_reg[ADDR_W];
    assign rd_data = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (busy) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // sweep writes zero, otherwise the one write port
    always_ff @(posedge aclk) begin
        if (busy) begin
            mem[clr_cnt_reg[ADDR_W-1:0]] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

endmodule

### rtl/grid_ray_march_dda.sv
// top level of the grid ray march block: sequencer, registers and ports
//
// Casts rays through a square map of 8-bit cell codes by DDA grid stepping and
// stores map writes. After reset the map is swept to zero with s_tready low;
// the config port works throughout. A ray word runs two squares on the shared
// multiplier, a bit-pair square root and two restoring divisions on the shared
// compare-subtract unit, two first-side products, then per grid step a step
// and compare, then the registered map read and wall test, and last the load
// of the result register. Only one ray is in flight; the block takes the next
// word once the last result is loaded into the result register. Position is
// Q6.16, direction Q2.14, distances Q16.16 saturating; cells wrap at the map
// edge, codes above 48 are walls, and max_steps of zero returns the start
// cell with timed_out set.
`include "grid_ray_march_dda_macros.svh"

module grid_ray_march_dda #(
    parameter int MAP_SIZE_LOG2 = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // cell_x[5:0], cell_y[11:6], cell_value[19:12], pos_x[41:20],
    // pos_y[63:42], dir_x[79:64], dir_y[95:80]
    input  logic [95:0] s_tdata,
    // op[0]
    input  logic [0:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // hit_x[5:0], hit_y[11:6], side[13:12], step_x_negative[14],
    // step_y_negative[15], side_dist_x[47:16], side_dist_y[79:48]
    output logic [79:0] m_tdata,
    // timed_out[0]
    output logic [0:0]  m_tuser,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW     = MAP_SIZE_LOG2;
    localparam int ADDR_W = 2 * MAP_SIZE_LOG2;
    localparam int FB     = grmd_pkg::FRAC_BITS;
    localparam int CW     = grmd_pkg::CMP_W;
    localparam int DW     = grmd_pkg::DIST_W;

    // unpacked input word
    logic [grmd_pkg::CELL_W-1:0]  in_cell_x, in_cell_y;
    logic [grmd_pkg::VALUE_W-1:0] in_value;
    logic [grmd_pkg::POS_W-1:0]   in_pos_x, in_pos_y;
    logic [grmd_pkg::DIR_W-1:0]   in_dir_x, in_dir_y;
    logic [31:0]                  wx_ext, wy_ext, px_ext, py_ext;

    assign in_cell_x = s_tdata[5:0];
    assign in_cell_y = s_tdata[11:6];
    assign in_value  = s_tdata[19:12];
    assign in_pos_x  = s_tdata[41:20];
    assign in_pos_y  = s_tdata[63:42];
    assign in_dir_x  = s_tdata[79:64];
    assign in_dir_y  = s_tdata[95:80];
    assign wx_ext    = 32'(in_cell_x);
    assign wy_ext    = 32'(in_cell_y);
    assign px_ext    = 32'(in_pos_x[grmd_pkg::POS_W-1:FB]);
    assign py_ext    = 32'(in_pos_y[grmd_pkg::POS_W-1:FB]);

    grmd_pkg::state_t state_reg, state_next;

    logic [grmd_pkg::STEPS_W-1:0] max_steps_reg;
    logic [grmd_pkg::STEPS_W-1:0] step_cnt_reg;
    logic [grmd_pkg::ITER_W-1:0]  iter_reg;
    logic                         iter_last;

    // ray working registers
    logic [grmd_pkg::POS_W-1:0]   pos_x_reg, pos_y_reg;
    logic                         neg_x_reg, neg_y_reg, timed_reg;
    logic [grmd_pkg::DIR_W-1:0]   mag_x_reg, mag_y_reg;
    logic [31:0]                  sum_reg, root_reg;
    logic [32:0]                  rem_reg;
    logic [63:0]                  wrk_reg;
    logic [DW-1:0]                delta_x_reg, delta_y_reg, dist_x_reg, dist_y_reg;
    logic [IW-1:0]                cur_x_reg, cur_y_reg;
    logic [1:0]                   side_reg;

    // result register
    logic                         m_valid_reg;
    logic [79:0]                  m_data_reg;
    logic                         m_timed_reg;

    // shared unit hookup
    logic [CW-1:0]                   alu_a, alu_b, alu_d;
    logic                            alu_ge;
    logic [grmd_pkg::MUL_A_W-1:0]    mul_a;
    logic [DW-1:0]                   mul_b;
    logic [grmd_pkg::MUL_P_W-1:0]    mul_p;

    // map hookup
    logic                         map_busy, map_wr;
    logic [ADDR_W-1:0]            map_wr_addr, map_rd_addr;
    logic [grmd_pkg::VALUE_W-1:0] map_rd_data;

    // misc datapath
    logic                         accept, cast_accept, can_load, wall;
    logic [grmd_pkg::FRAC_BITS:0] off_x, off_y;
    logic [32:0]                  fs_shift, add_x, add_y;
    logic [DW-1:0]                fs_val, sat_x, sat_y;
    logic [DW-1:0]                div_q;
    logic [IW-1:0]                step_x, step_y;
    logic [31:0]                  hx_ext, hy_ext;
    logic                         cfg_wr;

    grmd_alu u_alu (
        .cmp_a    (alu_a),
        .cmp_b    (alu_b),
        .cmp_ge   (alu_ge),
        .cmp_diff (alu_d),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .mul_p    (mul_p)
    );

    grmd_map #(.ADDR_W(ADDR_W)) u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (map_wr),
        .wr_addr (map_wr_addr),
        .wr_data (in_value),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data),
        .busy    (map_busy)
    );

    // config port: one register, written on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == grmd_pkg::REG_MAX_STEPS);
    assign prdata = (paddr[2] == grmd_pkg::REG_MAX_STEPS) ? 32'(max_steps_reg) : 32'd0;

    assign accept      = s_tvalid && s_tready;
    assign cast_accept = accept && (s_tuser[0] == grmd_pkg::OP_CAST);
    assign can_load    = !m_valid_reg || m_tready;
    assign iter_last   = (iter_reg == grmd_pkg::ITER_W'(grmd_pkg::ITERS - 1));
    assign wall        = map_rd_data > grmd_pkg::WALL_LEVEL;

    assign map_wr      = accept && (s_tuser[0] == grmd_pkg::OP_WRITE);
    assign map_wr_addr = {wy_ext[IW-1:0], wx_ext[IW-1:0]};

    // fractional offset to the first grid line
    assign off_x = neg_x_reg ? {1'b0, pos_x_reg[FB-1:0]}
                             : grmd_pkg::FRAC_ONE - {1'b0, pos_x_reg[FB-1:0]};
    assign off_y = neg_y_reg ? {1'b0, pos_y_reg[FB-1:0]}
                             : grmd_pkg::FRAC_ONE - {1'b0, pos_y_reg[FB-1:0]};
    assign fs_shift = mul_p[grmd_pkg::MUL_P_W-1:FB];
    assign fs_val   = fs_shift[32] ? '1 : fs_shift[31:0];

    // saturating side distance advance
    assign add_x = {1'b0, dist_x_reg} + {1'b0, delta_x_reg};
    assign add_y = {1'b0, dist_y_reg} + {1'b0, delta_y_reg};
    assign sat_x = add_x[32] ? '1 : add_x[31:0];
    assign sat_y = add_y[32] ? '1 : add_y[31:0];
    assign step_x = neg_x_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
    assign step_y = neg_y_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;

    // quotient after this division step
    assign div_q = {wrk_reg[30:0], alu_ge};

    assign hx_ext = 32'(cur_x_reg);
    assign hy_ext = 32'(cur_y_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            grmd_pkg::ST_IDLE: begin
                if (cast_accept) state_next = grmd_pkg::ST_SQ_X;
            end
            grmd_pkg::ST_SQ_X:  state_next = grmd_pkg::ST_SQ_Y;
            grmd_pkg::ST_SQ_Y:  state_next = grmd_pkg::ST_SQRT;
            grmd_pkg::ST_SQRT: begin
                if (iter_last) state_next = grmd_pkg::ST_DIV_X;
            end
            grmd_pkg::ST_DIV_X: begin
                if (iter_last) state_next = grmd_pkg::ST_DIV_Y;
            end
            grmd_pkg::ST_DIV_Y: begin
                if (iter_last) state_next = grmd_pkg::ST_FS_X;
            end
            grmd_pkg::ST_FS_X:  state_next = grmd_pkg::ST_FS_Y;
            grmd_pkg::ST_FS_Y: begin
                state_next = (max_steps_reg == '0) ? grmd_pkg::ST_OUT : grmd_pkg::ST_STEP;
            end
            grmd_pkg::ST_STEP:  state_next = grmd_pkg::ST_TEST;
            grmd_pkg::ST_TEST: begin
                if (wall || step_cnt_reg == max_steps_reg) state_next = grmd_pkg::ST_OUT;
                else state_next = grmd_pkg::ST_STEP;
            end
            grmd_pkg::ST_OUT: begin
                if (can_load) state_next = grmd_pkg::ST_IDLE;
            end
            default: state_next = grmd_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake, shared unit operands, map read address
    always_comb begin
        s_tready    = (state_reg == grmd_pkg::ST_IDLE) && !map_busy;
        alu_a       = '0;
        alu_b       = '0;
        mul_a       = '0;
        mul_b       = '0;
        map_rd_addr = {cur_y_reg, cur_x_reg};
        case (state_reg)
            grmd_pkg::ST_SQ_X: begin
                mul_a = grmd_pkg::MUL_A_W'(mag_x_reg);
                mul_b = DW'(mag_x_reg);
            end
            grmd_pkg::ST_SQ_Y: begin
                mul_a = grmd_pkg::MUL_A_W'(mag_y_reg);
                mul_b = DW'(mag_y_reg);
            end
            grmd_pkg::ST_SQRT: begin
                // bring down the next bit pair, trial is 4*root + 1
                alu_a = {rem_reg, wrk_reg[63:62]};
                alu_b = {1'b0, root_reg, 2'b01};
            end
            grmd_pkg::ST_DIV_X: begin
                alu_a = {18'd0, rem_reg[15:0], wrk_reg[31]};
                alu_b = CW'(mag_x_reg);
            end
            grmd_pkg::ST_DIV_Y: begin
                alu_a = {18'd0, rem_reg[15:0], wrk_reg[31]};
                alu_b = CW'(mag_y_reg);
            end
            grmd_pkg::ST_FS_X: begin
                mul_a = off_x;
                mul_b = delta_x_reg;
            end
            grmd_pkg::ST_FS_Y: begin
                mul_a = off_y;
                mul_b = delta_y_reg;
            end
            grmd_pkg::ST_STEP: begin
                // x steps when side_dist_x <= side_dist_y; read the cell entered
                alu_a = CW'(dist_y_reg);
                alu_b = CW'(dist_x_reg);
                map_rd_addr = alu_ge ? {cur_y_reg, step_x} : {step_y, cur_x_reg};
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= grmd_pkg::ST_IDLE;
            max_steps_reg <= grmd_pkg::STEPS_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) max_steps_reg <= pwdata[grmd_pkg::STEPS_W-1:0];
            if (state_reg == grmd_pkg::ST_OUT && can_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ray datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            grmd_pkg::ST_IDLE: begin
                if (cast_accept) begin
                    pos_x_reg    <= in_pos_x;
                    pos_y_reg    <= in_pos_y;
                    neg_x_reg    <= in_dir_x[grmd_pkg::DIR_W-1];
                    neg_y_reg    <= in_dir_y[grmd_pkg::DIR_W-1];
                    mag_x_reg    <= in_dir_x[grmd_pkg::DIR_W-1] ? -in_dir_x : in_dir_x;
                    mag_y_reg    <= in_dir_y[grmd_pkg::DIR_W-1] ? -in_dir_y : in_dir_y;
                    cur_x_reg    <= px_ext[IW-1:0];
                    cur_y_reg    <= py_ext[IW-1:0];
                    side_reg     <= grmd_pkg::SIDE_XP;
                    step_cnt_reg <= '0;
                end
            end
            grmd_pkg::ST_SQ_X: sum_reg <= mul_p[31:0];
            grmd_pkg::ST_SQ_Y: begin
                wrk_reg  <= {sum_reg + mul_p[31:0], 32'd0};
                rem_reg  <= '0;
                root_reg <= '0;
                iter_reg <= '0;
            end
            grmd_pkg::ST_SQRT: begin
                iter_reg <= iter_reg + 1'b1;
                root_reg <= {root_reg[30:0], alu_ge};
                if (iter_last) begin
                    wrk_reg <= {32'd0, root_reg[30:0], alu_ge};
                    rem_reg <= '0;
                end else begin
                    wrk_reg <= {wrk_reg[61:0], 2'b00};
                    rem_reg <= alu_ge ? alu_d[32:0] : alu_a[32:0];
                end
            end
            grmd_pkg::ST_DIV_X, grmd_pkg::ST_DIV_Y: begin
                iter_reg <= iter_reg + 1'b1;
                if (iter_last) begin
                    // divisor zero gives all ones, the saturated delta
                    if (state_reg == grmd_pkg::ST_DIV_X) delta_x_reg <= div_q;
                    else delta_y_reg <= div_q;
                    wrk_reg <= {32'd0, root_reg};
                    rem_reg <= '0;
                end else begin
                    wrk_reg <= {32'd0, div_q};
                    rem_reg <= {17'd0, alu_ge ? alu_d[15:0] : alu_a[15:0]};
                end
            end
            grmd_pkg::ST_FS_X: dist_x_reg <= fs_val;
            grmd_pkg::ST_FS_Y: begin
                dist_y_reg <= fs_val;
                timed_reg  <= 1'b1;
            end
            grmd_pkg::ST_STEP: begin
                step_cnt_reg <= step_cnt_reg + 1'b1;
                if (alu_ge) begin
                    dist_x_reg <= sat_x;
                    cur_x_reg  <= step_x;
                    side_reg   <= neg_x_reg ? grmd_pkg::SIDE_XN : grmd_pkg::SIDE_XP;
                end else begin
                    dist_y_reg <= sat_y;
                    cur_y_reg  <= step_y;
                    side_reg   <= neg_y_reg ? grmd_pkg::SIDE_YN : grmd_pkg::SIDE_YP;
                end
            end
            grmd_pkg::ST_TEST: timed_reg <= !wall;
            grmd_pkg::ST_OUT: begin
                if (can_load) begin
                    m_data_reg  <= {dist_y_reg, dist_x_reg, neg_y_reg, neg_x_reg,
                                    side_reg, hy_ext[5:0], hx_ext[5:0]};
                    m_timed_reg <= timed_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_timed_reg;

    `GRMD_ASSERT_IMP(a_no_word_while_clearing, map_busy, !s_tready, "word taken during map clear")
    `GRMD_ASSERT_IMP(a_step_under_limit, state_reg == grmd_pkg::ST_STEP, step_cnt_reg < max_steps_reg, "step past limit")
    `GRMD_ASSERT_NXT(a_result_loaded, state_reg == grmd_pkg::ST_OUT && can_load, m_valid_reg && state_reg == grmd_pkg::ST_IDLE, "result not loaded")
    `GRMD_ASSERT_NXT(a_sqrt_to_div, state_reg == grmd_pkg::ST_SQRT && iter_last, state_reg == grmd_pkg::ST_DIV_X && iter_reg == '0, "root not handed to divider")

endmodule
